// ----- design/lfu_pkg.sv -----
// ============================================================================
// lfu_pkg
// Shared types and constants for the LFU cache with LRU tie-break.
// ============================================================================
`default_nettype none

package lfu_pkg;

    localparam int unsigned ENTRIES_DEF    = 16;
    localparam int unsigned KEY_BITS_DEF   = 32;
    localparam int unsigned COUNT_BITS_DEF = 32;

    localparam int unsigned CFG_W      = 5;
    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

    typedef struct packed {
        logic               action;
        logic signed [31:0] lookup_key;
        logic signed [31:0] write_value;
    } t_req;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] read_value;
        logic               evicted;
        logic signed [31:0] evicted_key;
    } t_rsp;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_TOUCH  = 2'd1,
        OP_INSERT = 2'd2
    } t_op;

endpackage

`default_nettype wire

// ----- design/lfu_cell.sv -----
// ============================================================================
// lfu_cell
// One cache entry. Folds its entry into the scan record handed along the
// chain and applies the update broadcast at the end of each request.
// ============================================================================
`default_nettype none

module lfu_cell #(
    parameter int unsigned ENTRIES    = lfu_pkg::ENTRIES_DEF,
    parameter int unsigned KEY_BITS   = lfu_pkg::KEY_BITS_DEF,
    parameter int unsigned COUNT_BITS = lfu_pkg::COUNT_BITS_DEF,
    parameter int unsigned IDX        = 0,
    parameter type t_scan = logic,
    parameter type t_upd  = logic
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_scan i_scan,
    output t_scan      o_scan,
    input  wire t_upd  i_upd
);

    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic                  r_valid;
    logic [KEY_BITS-1:0]   r_key;
    logic [31:0]           r_val;
    logic [COUNT_BITS-1:0] r_cnt;
    logic [IDX_W-1:0]      r_rank;
    t_scan                 r_scan;
    t_scan                 n_scan;

    always_comb begin
        n_scan = i_scan;
        if (r_valid) begin
            n_scan.nvalid = i_scan.nvalid + 1'b1;
            if (!i_scan.found && r_key == i_upd.key) begin
                n_scan.found  = 1'b1;
                n_scan.f_idx  = MY_IDX;
                n_scan.f_val  = r_val;
                n_scan.f_rank = r_rank;
            end
            // Lowest count wins; on equal counts the older entry wins.
            if (!i_scan.vic || r_cnt < i_scan.v_cnt ||
                (r_cnt == i_scan.v_cnt && r_rank > i_scan.v_rank)) begin
                n_scan.vic    = 1'b1;
                n_scan.v_idx  = MY_IDX;
                n_scan.v_cnt  = r_cnt;
                n_scan.v_rank = r_rank;
                n_scan.v_key  = r_key;
            end
        end else if (!i_scan.inv) begin
            n_scan.inv     = 1'b1;
            n_scan.inv_idx = MY_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
    end

    assign o_scan = r_scan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            unique case (i_upd.op)
                lfu_pkg::OP_TOUCH: begin
                    if (i_upd.tgt == MY_IDX) begin
                        r_rank <= '0;
                        if (r_cnt != '1) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                        if (i_upd.put) begin
                            r_val <= i_upd.wval;
                        end
                    end else if (r_valid && r_rank < i_upd.tgt_rank) begin
                        r_rank <= r_rank + 1'b1;
                    end
                end
                lfu_pkg::OP_INSERT: begin
                    if (i_upd.ins_idx == MY_IDX) begin
                        r_valid <= 1'b1;
                        r_key   <= i_upd.key;
                        r_val   <= i_upd.wval;
                        r_cnt   <= COUNT_BITS'(1);
                        r_rank  <= '0;
                    end else if (i_upd.evict && i_upd.v_idx == MY_IDX) begin
                        r_valid <= 1'b0;
                    end else if (r_valid) begin
                        // Entries behind the victim close the gap and all shift
                        // back one for the new entry, so they keep their rank.
                        if (!(i_upd.evict && r_rank > i_upd.v_rank)) begin
                            r_rank <= r_rank + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- design/lfu_cache_with_lru_tiebreak_core.sv -----
// ============================================================================
// lfu_cache_with_lru_tiebreak_core
// Fully associative key/value cache, least-frequently-used replacement with
// least-recent tie-break, built as a chain of entry cells.
// ============================================================================
//
//  channel   | signals                         | handshake
//  ----------+---------------------------------+-------------------------
//  request   | i_req (t_req)                   | start & !busy
//  response  | o_rsp (t_rsp)                   | o_rsp_valid, one cycle
//  config    | i_cfg_data (capacity)           | i_cfg_valid & o_cfg_ready
//
// A request passes its scan record through every cell of the chain in
// state SCAN, applies the update in state APPLY, and the response shows
// in the cycle after APPLY. With capacity zero the response comes in the
// cycle after the request. Reset clears all valid bits and sets the
// capacity to 16. The response cannot be stalled; busy is high while a
// request is in the chain.
`default_nettype none

module lfu_cache_with_lru_tiebreak_core #(
    parameter int unsigned ENTRIES    = lfu_pkg::ENTRIES_DEF,
    parameter int unsigned KEY_BITS   = lfu_pkg::KEY_BITS_DEF,
    parameter int unsigned COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire lfu_pkg::t_req             i_req,
    output logic                           o_rsp_valid,
    output lfu_pkg::t_rsp                  o_rsp,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [lfu_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

    typedef struct packed {
        logic                  found;
        logic [IDX_W-1:0]      f_idx;
        logic [31:0]           f_val;
        logic [IDX_W-1:0]      f_rank;
        logic [CNT_W-1:0]      nvalid;
        logic                  inv;
        logic [IDX_W-1:0]      inv_idx;
        logic                  vic;
        logic [IDX_W-1:0]      v_idx;
        logic [COUNT_BITS-1:0] v_cnt;
        logic [IDX_W-1:0]      v_rank;
        logic [KEY_BITS-1:0]   v_key;
    } t_scan;

    typedef struct packed {
        lfu_pkg::t_op        op;
        logic                put;
        logic [IDX_W-1:0]    tgt;
        logic [IDX_W-1:0]    tgt_rank;
        logic [31:0]         wval;
        logic [KEY_BITS-1:0] key;
        logic                evict;
        logic [IDX_W-1:0]    v_idx;
        logic [IDX_W-1:0]    v_rank;
        logic [IDX_W-1:0]    ins_idx;
    } t_upd;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_APPLY = 3'b100
    } t_state;

    t_state                     r_state;
    logic [IDX_W-1:0]           r_cnt;
    lfu_pkg::t_req              r_req;
    logic [KEY_BITS-1:0]        r_key;
    logic [lfu_pkg::CFG_W-1:0]  r_cap;
    lfu_pkg::t_rsp              r_rsp;
    lfu_pkg::t_rsp              n_rsp;
    logic                       r_rsp_valid;

    t_scan                      chain [ENTRIES+1];
    t_scan                      fin;
    t_upd                       upd;
    logic [31:0]                key32;
    logic [31:0]                cap_eff;
    logic                       is_put;
    logic                       full;
    logic                       evict;

    assign chain[0] = '0;
    assign fin      = chain[ENTRIES];
    assign key32    = i_req.lookup_key;
    assign is_put   = (r_req.action == lfu_pkg::ACT_PUT);
    assign cap_eff  = (32'(r_cap) > ENTRIES) ? ENTRIES : 32'(r_cap);
    assign full     = (32'(fin.nvalid) >= cap_eff);
    assign evict    = is_put && !fin.found && full && fin.vic;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lfu_cell #(
            .ENTRIES    (ENTRIES),
            .KEY_BITS   (KEY_BITS),
            .COUNT_BITS (COUNT_BITS),
            .IDX        (g),
            .t_scan     (t_scan),
            .t_upd      (t_upd)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_scan  (chain[g]),
            .o_scan  (chain[g+1]),
            .i_upd   (upd)
        );
    end

    always_comb begin
        upd          = '0;
        upd.op       = lfu_pkg::OP_NONE;
        upd.put      = is_put;
        upd.tgt      = fin.f_idx;
        upd.tgt_rank = fin.f_rank;
        upd.wval     = r_req.write_value;
        upd.key      = r_key;
        upd.evict    = evict;
        upd.v_idx    = fin.v_idx;
        upd.v_rank   = fin.v_rank;
        // The new entry goes to the lowest free slot, the victim's included.
        if (evict && !(fin.inv && fin.inv_idx < fin.v_idx)) begin
            upd.ins_idx = fin.v_idx;
        end else begin
            upd.ins_idx = fin.inv_idx;
        end
        if (r_state == ST_APPLY) begin
            if (fin.found) begin
                upd.op = lfu_pkg::OP_TOUCH;
            end else if (is_put) begin
                upd.op = lfu_pkg::OP_INSERT;
            end
        end
    end

    always_comb begin
        n_rsp = '0;
        if (r_state == ST_APPLY) begin
            n_rsp.hit = fin.found;
            if (!is_put) begin
                n_rsp.read_value = fin.found ? fin.f_val : lfu_pkg::MISS_VALUE;
            end
            n_rsp.evicted = evict;
            if (evict) begin
                n_rsp.evicted_key = 32'(fin.v_key);
            end
        end else if (i_req.action == lfu_pkg::ACT_GET) begin
            n_rsp.read_value = lfu_pkg::MISS_VALUE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_cap       <= lfu_pkg::CAP_RESET;
            r_rsp_valid <= 1'b0;
        end else begin
            r_rsp_valid <= 1'b0;
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        if (r_cap == '0) begin
                            r_rsp_valid <= 1'b1;
                        end else begin
                            r_state <= ST_SCAN;
                            r_cnt   <= '0;
                        end
                    end
                end
                ST_SCAN: begin
                    if (32'(r_cnt) == ENTRIES - 1) begin
                        r_state <= ST_APPLY;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_APPLY: begin
                    r_state     <= ST_IDLE;
                    r_rsp_valid <= 1'b1;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && start) begin
            r_req <= i_req;
            r_key <= KEY_BITS'(key32);
        end
        if ((r_state == ST_IDLE && start) || r_state == ST_APPLY) begin
            r_rsp <= n_rsp;
        end
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

// ----- design/lfu_chk.sv -----
// ============================================================================
// lfu_chk
// Port-level checks on the LFU cache core, bound to the top level.
// ============================================================================
`default_nettype none

module lfu_chk (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire logic          o_rsp_valid,
    input wire lfu_pkg::t_rsp o_rsp
);

    // A response only comes once the chain has finished the request.
    a_rsp_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> !busy)
        else $error("response while busy");

    a_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.evicted |-> !o_rsp.hit && o_rsp.read_value == 0)
        else $error("eviction on a hit or a get");

    // A miss answers either -1 (get) or 0 (put).
    a_miss_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_rsp.hit |-> o_rsp.read_value == 0 || o_rsp.read_value == -1)
        else $error("bad miss value");

    a_busy_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy without a request");

endmodule

bind lfu_cache_with_lru_tiebreak_core lfu_chk u_lfu_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_rsp_valid (o_rsp_valid),
    .o_rsp       (o_rsp)
);

`default_nettype wire

// ----- test/lfu_checker.sv -----
// ============================================================================
// lfu_checker
// Watches the request, response and capacity channels of the LFU cache,
// keeps its own copy of the cache contents, predicts every response and
// compares it field by field with what the cache returns.
// ============================================================================
module lfu_checker #(
    parameter int unsigned SLOTS = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    input  wire logic                      busy,
    input  wire lfu_pkg::t_req             i_req,
    input  wire logic                      o_rsp_valid,
    input  wire lfu_pkg::t_rsp             o_rsp,
    input  wire logic                      i_cfg_valid,
    input  wire logic                      o_cfg_ready,
    input  wire logic [lfu_pkg::CFG_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic        slot_valid [SLOTS];
    logic [31:0] slot_key   [SLOTS];
    logic [31:0] slot_value [SLOTS];
    logic [31:0] slot_uses  [SLOTS];
    int          slot_age   [SLOTS];
    logic [lfu_pkg::CFG_W-1:0] capacity;
    lfu_pkg::t_rsp expected_rsps[$];

    // Counts up by one on each use and makes the slot the most recent.
    function automatic void bump_slot(int s);
        for (int j = 0; j < SLOTS; j++) begin
            if (slot_valid[j] && slot_age[j] < slot_age[s]) begin
                slot_age[j]++;
            end
        end
        slot_age[s] = 0;
        if (slot_uses[s] != 32'hFFFF_FFFF) begin
            slot_uses[s]++;
        end
    endfunction

    function automatic lfu_pkg::t_rsp lookup_and_update(lfu_pkg::t_req r);
        lfu_pkg::t_rsp rsp;
        int          cap;
        int          found;
        int          used;
        int          victim;
        int          vage;
        logic [31:0] k;
        rsp    = '0;
        cap    = (capacity > SLOTS) ? SLOTS : capacity;
        found  = -1;
        used   = 0;
        victim = -1;
        k      = r.lookup_key;
        if (cap == 0) begin
            if (r.action == lfu_pkg::ACT_GET) begin
                rsp.read_value = lfu_pkg::MISS_VALUE;
            end
            return rsp;
        end
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (slot_valid[i] && slot_key[i] == k) begin
                found = i;
            end
        end
        if (found >= 0) begin
            rsp.hit = 1'b1;
            if (r.action == lfu_pkg::ACT_GET) begin
                rsp.read_value = slot_value[found];
            end else begin
                slot_value[found] = r.write_value;
            end
            bump_slot(found);
            return rsp;
        end
        if (r.action == lfu_pkg::ACT_GET) begin
            rsp.read_value = lfu_pkg::MISS_VALUE;
            return rsp;
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_valid[i]) begin
                used++;
            end
        end
        if (used >= cap) begin
            // Fewest uses goes first; among equals, the oldest.
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_valid[i] && (victim < 0 || slot_uses[i] < slot_uses[victim] ||
                        (slot_uses[i] == slot_uses[victim] &&
                         slot_age[i] > slot_age[victim]))) begin
                    victim = i;
                end
            end
            vage = slot_age[victim];
            slot_valid[victim] = 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_valid[i] && slot_age[i] > vage) begin
                    slot_age[i]--;
                end
            end
            rsp.evicted     = 1'b1;
            rsp.evicted_key = slot_key[victim];
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_valid[i]) begin
                slot_age[i]++;
            end
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (!slot_valid[i]) begin
                slot_valid[i] = 1'b1;
                slot_key[i]   = k;
                slot_value[i] = r.write_value;
                slot_uses[i]  = 32'd1;
                slot_age[i]   = 0;
                break;
            end
        end
        return rsp;
    endfunction

    always_ff @(posedge i_clk) begin
        lfu_pkg::t_rsp want;
        int            errs;
        errs = 0;
        if (!i_rst_n) begin
            capacity     <= lfu_pkg::CAP_RESET;
            o_fail_count <= 0;
            for (int i = 0; i < SLOTS; i++) begin
                slot_valid[i] = 1'b0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                capacity <= i_cfg_data;
            end
            if (o_rsp_valid) begin
                if (expected_rsps.size() == 0) begin
                    $error("response with no request outstanding");
                    errs++;
                end else begin
                    want = expected_rsps.pop_front();
                    if (o_rsp.hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, o_rsp.hit);
                        errs++;
                    end
                    if (o_rsp.read_value !== want.read_value) begin
                        $error("read_value: expected %h, got %h",
                               want.read_value, o_rsp.read_value);
                        errs++;
                    end
                    if (o_rsp.evicted !== want.evicted) begin
                        $error("evicted: expected %0d, got %0d",
                               want.evicted, o_rsp.evicted);
                        errs++;
                    end
                    if (o_rsp.evicted_key !== want.evicted_key) begin
                        $error("evicted_key: expected %h, got %h",
                               want.evicted_key, o_rsp.evicted_key);
                        errs++;
                    end
                end
            end
            if (start && !busy) begin
                expected_rsps.push_back(lookup_and_update(i_req));
            end
            o_fail_count <= o_fail_count + errs;
        end
        o_pending <= expected_rsps.size();
    end

endmodule

// ----- test/testbench.sv -----
// ============================================================================
// testbench
// Drives the LFU cache with directed and random gets and puts over several
// capacity settings, with random gaps between requests; the checker beside
// the cache predicts and compares every response.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 400000;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    lfu_pkg::t_req             i_req = '0;
    logic                      o_rsp_valid;
    lfu_pkg::t_rsp             o_rsp;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [lfu_pkg::CFG_W-1:0] i_cfg_data = '0;
    int                        fail_count;
    int                        pending;
    int                        cycles = 0;
    logic [31:0]               key_pool[24];
    bit                        no_gaps;

    lfu_cache_with_lru_tiebreak_core dut (.*);

    lfu_checker #(.SLOTS(lfu_pkg::ENTRIES_DEF)) u_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_req, .o_rsp_valid, .o_rsp,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_request(logic act, logic [31:0] k, logic [31:0] v);
        int gap;
        i_req <= '{action: act, lookup_key: k, write_value: v};
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Capacity changes only once the cache has drained.
    task automatic set_capacity(logic [lfu_pkg::CFG_W-1:0] cap);
        start <= 1'b0;
        wait (pending == 0);
        repeat (24) @(posedge i_clk);
        i_cfg_data  <= cap;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_requests(int n, int pool_n);
        logic [31:0] k;
        for (int i = 0; i < n; i++) begin
            if (i % 60 == 0) begin
                no_gaps = ($urandom_range(0, 2) == 0);
            end
            k = ($urandom_range(0, 9) == 0) ? $urandom()
                                            : key_pool[$urandom_range(0, pool_n - 1)];
            send_request($urandom_range(0, 1) ? lfu_pkg::ACT_PUT : lfu_pkg::ACT_GET,
                         k, $urandom());
        end
    endtask

    initial begin
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'h7FFF_FFFF;
        for (int i = 4; i < 24; i++) begin
            key_pool[i] = $urandom();
        end
        no_gaps = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, miss on empty, update, then a full cache
        // where the oldest of the single-use entries is evicted.
        send_request(lfu_pkg::ACT_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(lfu_pkg::ACT_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(lfu_pkg::ACT_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(lfu_pkg::ACT_GET, 32'h8000_0000, 32'h0);
        send_request(lfu_pkg::ACT_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(lfu_pkg::ACT_GET, 32'h7FFF_FFFF, 32'h0);
        for (int i = 0; i < 16; i++) begin
            send_request(lfu_pkg::ACT_PUT, 32'h100 + i, ~i);
        end
        send_request(lfu_pkg::ACT_GET, 32'hFFFF_FFFF, 32'h0);

        random_requests(150, 24);
        set_capacity(5'd0);
        send_request(lfu_pkg::ACT_GET, key_pool[0], 32'h0);
        send_request(lfu_pkg::ACT_PUT, 32'h55AA_55AA, 32'h1234_5678);
        random_requests(20, 24);
        // Shrink below the stored count: each put miss evicts just one.
        set_capacity(5'd2);
        random_requests(80, 12);
        set_capacity(5'd1);
        random_requests(80, 6);
        set_capacity(5'd31);
        random_requests(150, 24);
        start <= 1'b0;
        wait (pending == 0);
        set_capacity(5'd5);
        random_requests(150, 10);
        set_capacity(5'd16);
        random_requests(200, 20);

        start <= 1'b0;
        wait (pending == 0);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
